// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, prop, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/core/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Widths, register indexes, sequencer states and saturation helpers for the
// pulse rate detector.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COUNT_BITS     = 16;
  localparam int COEF_BITS      = 15;
  localparam int ACC_BITS       = 24;
  localparam int THR_BITS       = 16;
  localparam int NUM_BITS       = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Product of unsigned coefficient and signed accumulator value.
  localparam int PROD_BITS = COEF_BITS + 1 + ACC_BITS;
  localparam int Q_BITS    = PROD_BITS - COEF_FRAC_BITS;
  // Headroom for sums before saturation.
  localparam int SUM_BITS  = ACC_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam logic [COEF_BITS-1:0] DC_ALPHA_RST   = COEF_BITS'(27853);
  localparam logic [COEF_BITS-1:0] LP_IN_GAIN_RST = COEF_BITS'(8036);
  localparam logic [COEF_BITS-1:0] LP_FB_GAIN_RST = COEF_BITS'(16696);
  localparam logic [THR_BITS-1:0]  FALL_THR_RST   = THR_BITS'(20);
  localparam logic [NUM_BITS-1:0]  RATE_NUM_RST   = NUM_BITS'(1200);

  localparam logic [CFG_IDX_BITS-1:0] REG_DC_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_IN_GAIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_FB_GAIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_THR   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_NUM   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DC,
    ST_ADD_DC,
    ST_MUL_IN,
    ST_ADD_IN,
    ST_MUL_FB,
    ST_ADD_FB,
    ST_DETECT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WB
  } prd_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [SUM_BITS-1:0] sext_acc(
    input logic signed [ACC_BITS-1:0] v);
    return {{(SUM_BITS-ACC_BITS){v[ACC_BITS-1]}}, v};
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sext_q(
    input logic signed [Q_BITS-1:0] v);
    return {{(SUM_BITS-Q_BITS){v[Q_BITS-1]}}, v};
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_acc(
    input logic signed [SUM_BITS-1:0] v);
    logic [SUM_BITS-ACC_BITS:0] top;
    logic signed [ACC_BITS-1:0] r;
    top = v[SUM_BITS-1:ACC_BITS-1];
    if (top == '0 || top == '1) begin
      r = v[ACC_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/prd_div.sv
// ----------------------------------------------------------------------------
// prd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prd_div
  import prd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctl_t              ctl,
  input  logic [NUM_BITS-1:0]   num,
  input  logic [COUNT_BITS-1:0] den,
  output div_sts_t              sts,
  output logic [NUM_BITS-1:0]   quo
);

  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   den_r;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     diff;

  assign shifted = {rem, quo[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      // keep the trial difference when the divisor fits
      if (!diff[COUNT_BITS]) begin
        rem <= diff[COUNT_BITS-1:0];
        quo <= {quo[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[COUNT_BITS-1:0];
        quo <= {quo[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// File: rtl/core/pulse_rate_detector_top.sv
// ----------------------------------------------------------------------------
// pulse_rate_detector_top
// Optical pulse-rate detector: DC removal, first-order low-pass, beat
// detection and rate computation on one shared multiplier and a serial divider.
//
//   channel   ports                             word contents
//   input     s_tvalid s_tready s_tdata[15:0]   sample
//   output    m_tvalid m_tready m_tdata[39:0]   filtered, rate
//             m_tuser[0:0]                      beat
//   config    cfg_we cfg_index cfg_wdata        register write, no read-back
//
// Each word passes three multiplies on the shared multiplier and 16 divider
// steps before it reaches the output register; a new word is accepted only
// after the previous one has been written to the output register.
// rst is synchronous and restores filter state and register defaults.
// A stalled output holds its word; the next result waits until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_rate_detector_top
  import prd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [15:0]              s_tdata,   // [15:0] sample
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [39:0]              m_tdata,   // [23:0] filtered, [39:24] rate
  output logic [0:0]               m_tuser,   // [0] beat
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  prd_state_t state, state_next;

  logic [COEF_BITS-1:0]  dc_alpha;
  logic [COEF_BITS-1:0]  lp_input_gain;
  logic [COEF_BITS-1:0]  lp_feedback_gain;
  logic [THR_BITS-1:0]   fall_threshold;
  logic [NUM_BITS-1:0]   rate_numerator;

  logic [SAMPLE_BITS-1:0]     sample_r;
  logic signed [ACC_BITS-1:0] dc_accum;
  logic signed [ACC_BITS-1:0] lp_prev;
  logic signed [ACC_BITS-1:0] last_output;
  logic signed [ACC_BITS-1:0] y_r;
  logic signed [ACC_BITS-1:0] filt_r;
  logic signed [Q_BITS-1:0]   t_r;
  logic signed [PROD_BITS-1:0] prod;
  logic                       in_pulse;
  logic [COUNT_BITS-1:0]      samples_since_beat;
  logic [COUNT_BITS-1:0]      beat_period;
  logic                       beat_r;
  logic [NUM_BITS-1:0]        rate_r;

  logic [COEF_BITS-1:0]       mul_coef;
  logic signed [ACC_BITS-1:0] mul_opnd;
  logic signed [Q_BITS-1:0]   q;
  logic signed [ACC_BITS-1:0] w;
  logic signed [ACC_BITS-1:0] c;
  logic signed [SUM_BITS-1:0] fire_lim;
  logic                       armed;
  logic                       fire;
  logic [COUNT_BITS-1:0]      count_base;
  logic                       out_free;

  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [NUM_BITS-1:0]   div_quo;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_alpha         <= DC_ALPHA_RST;
      lp_input_gain    <= LP_IN_GAIN_RST;
      lp_feedback_gain <= LP_FB_GAIN_RST;
      fall_threshold   <= FALL_THR_RST;
      rate_numerator   <= RATE_NUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DC_ALPHA:   dc_alpha         <= cfg_wdata[COEF_BITS-1:0];
        REG_LP_IN_GAIN: lp_input_gain    <= cfg_wdata[COEF_BITS-1:0];
        REG_LP_FB_GAIN: lp_feedback_gain <= cfg_wdata[COEF_BITS-1:0];
        REG_FALL_THR:   fall_threshold   <= cfg_wdata[THR_BITS-1:0];
        REG_RATE_NUM:   rate_numerator   <= cfg_wdata[NUM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_coef = dc_alpha;
    mul_opnd = dc_accum;
    case (state)
      ST_MUL_IN: begin
        mul_coef = lp_input_gain;
        mul_opnd = y_r;
      end
      ST_MUL_FB: begin
        mul_coef = lp_feedback_gain;
        mul_opnd = lp_prev;
      end
      default: ;
    endcase
  end

  // floor of product / 2^COEF_FRAC_BITS
  assign q = prod[PROD_BITS-1:COEF_FRAC_BITS];

  assign w = sat_acc({{(SUM_BITS-SAMPLE_BITS){1'b0}}, sample_r} + sext_q(q));
  assign c = sat_acc(sext_q(t_r) + sext_q(q));

  assign fire_lim = sext_acc(last_output) - {{(SUM_BITS-THR_BITS){1'b0}}, fall_threshold};
  assign armed    = in_pulse || (filt_r > last_output);
  assign fire     = armed && (sext_acc(filt_r) <= fire_lim);
  assign count_base = fire ? '0 : samples_since_beat;

  assign out_free = !m_tvalid || m_tready;

  // sequencer
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    div_ctl.start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_MUL_DC;
      end
      ST_MUL_DC:   state_next = ST_ADD_DC;
      ST_ADD_DC:   state_next = ST_MUL_IN;
      ST_MUL_IN:   state_next = ST_ADD_IN;
      ST_ADD_IN:   state_next = ST_MUL_FB;
      ST_MUL_FB:   state_next = ST_ADD_FB;
      ST_ADD_FB:   state_next = ST_DETECT;
      ST_DETECT:   state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_ctl.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_sts.done) state_next = ST_WB;
      ST_WB:       if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // filter and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_accum           <= '0;
      lp_prev            <= '0;
      last_output        <= '0;
      in_pulse           <= 1'b0;
      samples_since_beat <= '0;
      beat_period        <= '0;
    end else begin
      case (state)
        ST_ADD_DC: dc_accum <= w;
        ST_ADD_FB: lp_prev  <= c;
        ST_DETECT: begin
          last_output <= filt_r;
          in_pulse    <= armed && !fire;
          if (fire) beat_period <= samples_since_beat;
          if (count_base != '1) begin
            samples_since_beat <= count_base + 1'b1;
          end else begin
            samples_since_beat <= count_base;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) sample_r <= s_tdata[SAMPLE_BITS-1:0];
    if (state == ST_MUL_DC || state == ST_MUL_IN || state == ST_MUL_FB) begin
      prod <= $signed({1'b0, mul_coef}) * mul_opnd;
    end
    if (state == ST_ADD_DC) y_r <= sat_acc(sext_acc(w) - sext_acc(dc_accum));
    if (state == ST_ADD_IN) t_r <= q;
    if (state == ST_ADD_FB) filt_r <= sat_acc(sext_acc(c) + sext_acc(lp_prev));
    if (state == ST_DETECT) beat_r <= fire;
    if (state == ST_DIV_WAIT && div_sts.done) begin
      rate_r <= (beat_period == '0) ? '0 : div_quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_WB && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && out_free) begin
      m_tdata <= {rate_r, filt_r};
      m_tuser <= beat_r;
    end
  end

  prd_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (rate_numerator),
    .den (beat_period),
    .sts (div_sts),
    .quo (div_quo)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input accepted while a word is in work")
  `ASSERT_ALWAYS(a_div_done_in_wait, clk, rst, !div_sts.done || state == ST_DIV_WAIT, "divider finished outside its wait state")
  `ASSERT_ALWAYS(a_div_busy_in_wait, clk, rst, !div_sts.busy || state == ST_DIV_WAIT, "divider busy outside its wait state")
  `ASSERT_NEXT(a_beat_restarts_count, clk, rst, state == ST_DETECT && fire, samples_since_beat == COUNT_BITS'(1) && !in_pulse, "beat did not restart the period count")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse rate detector testbench
// Streams raw optical samples into pulse_rate_detector_top. Directed extremes
// come first, then synthetic pulse trains with noise under several register
// settings. A predictor of DC removal, low-pass, beat detection
// and rate division checks every output word in order. Random idles on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import prd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint SAT_HI = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (ACC_BITS - 1));

  typedef struct packed {
    logic [ACC_BITS-1:0] filtered;
    logic                beat;
    logic [15:0]         rate;
  } pulse_result_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [15:0]              s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [39:0]              m_tdata;
  logic [0:0]               m_tuser;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // predictor registers and filter state
  logic [COEF_BITS-1:0]       cfg_alpha;
  logic [COEF_BITS-1:0]       cfg_gain_in;
  logic [COEF_BITS-1:0]       cfg_gain_fb;
  logic [THR_BITS-1:0]        cfg_fall_thr;
  logic [NUM_BITS-1:0]        cfg_rate_num;
  logic signed [ACC_BITS-1:0] hp_w;
  logic signed [ACC_BITS-1:0] lp_c;
  logic signed [ACC_BITS-1:0] last_filt;
  logic                       armed;
  logic [COUNT_BITS-1:0]      since_beat;
  logic [COUNT_BITS-1:0]      period;

  pulse_result_t expected_q[$];
  pulse_result_t want;

  bit in_idle_en;
  bit out_stall_en;
  int errors;
  int cycle_count;
  int items_sent;
  int results_seen;
  int beats_seen;
  int sat_seen;
  int peak_rate;
  int settings_used;

  pulse_rate_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_acc(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // floor(k * v / 2^F): arithmetic shift floors toward minus infinity
  function automatic longint coef_scale(input logic [COEF_BITS-1:0] k, input longint v);
    return (longint'(k) * v) >>> COEF_FRAC_BITS;
  endfunction

  function automatic pulse_result_t predict_sample(input logic [SAMPLE_BITS-1:0] smp);
    longint w;
    longint y;
    longint c;
    longint f;
    pulse_result_t r;
    r.beat = 1'b0;
    w = clamp_acc(longint'(smp) + coef_scale(cfg_alpha, longint'(hp_w)));
    y = clamp_acc(w - longint'(hp_w));
    hp_w = ACC_BITS'(w);
    c = clamp_acc(coef_scale(cfg_gain_in, y) + coef_scale(cfg_gain_fb, longint'(lp_c)));
    f = clamp_acc(c + longint'(lp_c));
    lp_c = ACC_BITS'(c);
    // arm on a rise, then fire on a large enough drop
    if (!armed && f > longint'(last_filt)) armed = 1'b1;
    if (armed && f <= longint'(last_filt) - longint'(cfg_fall_thr)) begin
      period     = since_beat;
      since_beat = '0;
      armed      = 1'b0;
      r.beat     = 1'b1;
    end
    if (since_beat != '1) since_beat = since_beat + 1'b1;
    last_filt = ACC_BITS'(f);
    r.filtered = ACC_BITS'(f);
    r.rate = (period == '0) ? 16'd0 : 16'(cfg_rate_num / period);
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
    if (in_idle_en && $urandom_range(0, 99) < 22) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = 16'($urandom_range(0, 65535));
      repeat ($urandom_range(0, 39)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(predict_sample(smp));
    items_sent++;
  endtask

  // drop valid, wait for every pending word, then let the sequencer settle
  task automatic drain_results;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_DC_ALPHA:   cfg_alpha    = val[COEF_BITS-1:0];
      REG_LP_IN_GAIN: cfg_gain_in  = val[COEF_BITS-1:0];
      REG_LP_FB_GAIN: cfg_gain_fb  = val[COEF_BITS-1:0];
      REG_FALL_THR:   cfg_fall_thr = val[THR_BITS-1:0];
      REG_RATE_NUM:   cfg_rate_num = val[NUM_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] alpha, input logic [15:0] gain_in,
                              input logic [15:0] gain_fb, input logic [15:0] thr,
                              input logic [15:0] num);
    write_reg(REG_DC_ALPHA, alpha);
    write_reg(REG_LP_IN_GAIN, gain_in);
    write_reg(REG_LP_FB_GAIN, gain_fb);
    write_reg(REG_FALL_THR, thr);
    write_reg(REG_RATE_NUM, num);
    settings_used++;
  endtask

  // synthetic heartbeat: fast rise, slower fall, noise and rare outliers
  task automatic run_pulses(input int count, input int len_lo, input int len_hi,
                            input int amp_hi);
    int base;
    int amp;
    int len;
    int pos;
    int rise;
    int lvl;
    int noise;
    int v;
    base = $urandom_range(0, 65535 - amp_hi);
    len  = 0;
    pos  = 0;
    amp  = 0;
    rise = 1;
    for (int n = 0; n < count; n++) begin
      if (pos >= len) begin
        len  = $urandom_range(len_lo, len_hi);
        amp  = $urandom_range(amp_hi / 8, amp_hi);
        rise = len / 3 + 1;
        pos  = 0;
      end
      if (pos < rise) lvl = amp * pos / rise;
      else lvl = amp * (len - pos) / (len - rise + 1);
      noise = $urandom_range(0, 63);
      v = base + lvl + noise - 32;
      if ($urandom_range(0, 99) < 4) v = $urandom_range(0, 65535);
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      send_sample(16'(v));
      pos++;
    end
  endtask

  task automatic test_directed_extremes;
    logic [15:0] pts[] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                           16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA,
                           16'd1000, 16'd3000, 16'd6000, 16'd9000, 16'd7000, 16'd4000,
                           16'd1000, 16'd0, 16'd0, 16'd5000, 16'd20000, 16'd0};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_register_map;
    // spare indexes must not disturb any register
    for (int i = REG_RATE_NUM + 1; i < 2 ** CFG_IDX_BITS; i++)
      write_reg(CFG_IDX_BITS'(i), 16'($urandom_range(0, 65535)));
    run_pulses(20, 10, 30, 8000);
    // top bit of a coefficient write is dropped
    write_reg(REG_DC_ALPHA, 16'hC000);
    write_reg(REG_LP_IN_GAIN, 16'hFFFF);
    write_reg(REG_FALL_THR, 16'd0);
    write_reg(REG_RATE_NUM, 16'd0);
    run_pulses(40, 8, 40, 12000);
    program_regs(16'(DC_ALPHA_RST), 16'(LP_IN_GAIN_RST), 16'(LP_FB_GAIN_RST),
                 16'(FALL_THR_RST), 16'(RATE_NUM_RST));
  endtask

  task automatic test_pulse_train;
    run_pulses(100, 12, 50, 20000);
    drain_results();
    run_pulses(100, 20, 150, 30000);
    // long stretch with no idling on either side
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    run_pulses(200, 10, 60, 40000);
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
  endtask

  task automatic test_setting_sweep;
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_pulses(50, 10, 40, 30000);

    // saturate the DC accumulator and the low-pass, then swing down
    program_regs(16'd32767, 16'd32767, 16'd32767, 16'd65535, 16'd65535);
    for (int n = 0; n < 150; n++) send_sample(16'hFFFF);
    for (int n = 0; n < 40; n++) send_sample(16'h0000);
    run_pulses(40, 6, 20, 65535);

    program_regs(16'd32767, 16'd32767, 16'd0, 16'd0, 16'd1);
    run_pulses(60, 8, 40, 40000);

    program_regs(16'd0, 16'd32767, 16'd32767, 16'd1, 16'd65535);
    run_pulses(60, 8, 40, 20000);

    repeat (3) begin
      program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 400)),
                   16'($urandom_range(1, 65535)));
      run_pulses(70, 8, 150, 30000);
    end

    program_regs(16'(DC_ALPHA_RST), 16'(LP_IN_GAIN_RST), 16'(LP_FB_GAIN_RST),
                 16'(FALL_THR_RST), 16'(RATE_NUM_RST));
    run_pulses(60, 10, 50, 25000);
  endtask

  // output side: random stalls, sampled by the DUT at the rising edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = !(out_stall_en && $urandom_range(0, 99) < 22);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: filtered %0d beat %b rate %0d", $time,
                 $signed(m_tdata[23:0]), m_tuser[0], m_tdata[39:24]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata[23:0] !== want.filtered) begin
          $display("%0t: filtered expected %0d got %0d", $time,
                   $signed(want.filtered), $signed(m_tdata[23:0]));
          errors++;
        end
        if (m_tuser[0] !== want.beat) begin
          $display("%0t: beat expected %b got %b", $time, want.beat, m_tuser[0]);
          errors++;
        end
        if (m_tdata[39:24] !== want.rate) begin
          $display("%0t: rate expected %0d got %0d", $time, want.rate, m_tdata[39:24]);
          errors++;
        end
        if (want.beat) beats_seen++;
        if ($signed(want.filtered) == SAT_HI || $signed(want.filtered) == SAT_LO)
          sat_seen++;
        if (int'(want.rate) > peak_rate) peak_rate = int'(want.rate);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words pending", $time, expected_q.size());
      $display("** pulse_rate_detector_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
    cfg_alpha    = DC_ALPHA_RST;
    cfg_gain_in  = LP_IN_GAIN_RST;
    cfg_gain_fb  = LP_FB_GAIN_RST;
    cfg_fall_thr = FALL_THR_RST;
    cfg_rate_num = RATE_NUM_RST;
    hp_w         = '0;
    lp_c         = '0;
    last_filt    = '0;
    armed        = 1'b0;
    since_beat   = '0;
    period       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_register_map();
    test_pulse_train();
    test_setting_sweep();

    drain_results();
    repeat (60) @(posedge clk);

    $display("Run: %0d samples in, %0d words checked, %0d register settings", items_sent,
             results_seen, settings_used);
    $display("Seen: %0d beats, %0d saturated outputs, peak rate %0d", beats_seen, sat_seen,
             peak_rate);
    if (errors == 0 && expected_q.size() == 0)
      $display("** pulse_rate_detector_top: PASSED **");
    else
      $display("** pulse_rate_detector_top: FAILED **");
    $finish;
  end

endmodule
